@@ sv/mavf_pkg.sv @@
package mavf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int COUNT_W  = 5;
    localparam int FRAC_W   = 8;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_HOLD   = 4'b1000
    } mavf_state_t;

    typedef struct packed {
        logic done;
        logic busy;
    } mavf_status_t;

endpackage

@@ sv/mavf_window.sv @@
module mavf_window
    import mavf_pkg::*;
#(
    parameter int WINDOW = 16,
    parameter int SUM_W  = 20,
    parameter int CNT_W  = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SAMPLE_W-1:0] sample,
    output mavf_status_t               status,
    output logic signed [SUM_W-1:0]    sum,
    output logic [CNT_W-1:0]           count
);

    localparam int POS_W = $clog2(WINDOW);

    logic [SAMPLE_W-1:0]        mem [WINDOW];
    logic [SAMPLE_W-1:0]        rd_data_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic                       busy_reg;
    logic                       done_reg;
    logic [POS_W-1:0]           wpos_reg;
    logic [POS_W-1:0]           wpos_next;
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SAMPLE_W-1:0] old_sample;
    logic                       filling;

    // slots beyond the fill count have not been written since reset, so they read as zero
    assign filling    = (fill_reg < CNT_W'(WINDOW));
    assign old_sample = filling ? '0 : $signed(rd_data_reg);

    always_comb
    begin
        sum_next  = sum_reg + SUM_W'(sample_reg) - SUM_W'(old_sample);
        fill_next = filling ? fill_reg + 1'b1 : fill_reg;
        if (wpos_reg == POS_W'(WINDOW - 1))
        begin
            wpos_next = '0;
        end
        else
        begin
            wpos_next = wpos_reg + 1'b1;
        end
    end

    // ring memory, one read on accept and one write-back in the following cycle
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[wpos_reg] <= sample_reg;
        end
        if (start)
        begin
            rd_data_reg <= mem[wpos_reg];
            sample_reg  <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            wpos_reg <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                wpos_reg <= wpos_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign sum         = sum_reg;
    assign count       = fill_reg;

endmodule

@@ sv/mavf_divider.sv @@
module mavf_divider
    import mavf_pkg::*;
#(
    parameter int SUM_W = 20,
    parameter int CNT_W = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [SUM_W-1:0]  sum,
    input  logic [CNT_W-1:0]         divisor,
    output mavf_status_t             status,
    output logic signed [MEAN_W-1:0] mean
);

    localparam int DVD_W  = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         rem_next;
    logic [DVD_W-1:0]         quo_reg;
    logic [DVD_W-1:0]         quo_next;
    logic [CNT_W-1:0]         dvs_reg;
    logic                     neg_reg;
    logic signed [MEAN_W-1:0] mean_reg;

    logic [SUM_W-1:0]         sum_u;
    logic [SUM_W-1:0]         mag;
    logic [CNT_W:0]           trial;
    logic [CNT_W:0]           diff;
    logic                     fits;
    logic [MEAN_W-1:0]        q;

    assign sum_u = $unsigned(sum);
    assign mag   = sum[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
        q        = quo_next[MEAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {mag, {FRAC_W{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= sum[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            if (step_reg == STEP_W'(1))
            begin
                mean_reg <= neg_reg ? $signed(~q + 1'b1) : $signed(q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign mean        = mean_reg;

endmodule

@@ sv/moving_average_filter_core.sv @@
// an accepted beat passes through the window update (running sum and fill count registers),
// the bit-serial divider that forms the mean from the running sum and the fill count, and the
// output beat register; a new beat is accepted only once the last mean has been loaded into
// the output beat register, which waits while an unconsumed output beat is stalled
// reset: rst_n clears write position, fill count, running sum and handshake state;
// the ring memory is not swept, slots past the fill count read as zero
module moving_average_filter_core
    import mavf_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [MEAN_W-1:0]   mean_value,
    output logic [COUNT_W-1:0]         samples_counted
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    mavf_state_t              state_reg;
    mavf_state_t              state_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic                     accept;
    logic                     slot_free;
    logic                     load;
    mavf_status_t             win_status;
    mavf_status_t             div_status;
    logic signed [SUM_W-1:0]  win_sum;
    logic [CNT_W-1:0]         win_count;
    logic signed [MEAN_W-1:0] div_mean;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    mavf_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W),
        .CNT_W  (CNT_W)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (sample),
        .status (win_status),
        .sum    (win_sum),
        .count  (win_count)
    );

    mavf_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (win_status.done),
        .sum     (win_sum),
        .divisor (win_count),
        .status  (div_status),
        .mean    (div_mean)
    );

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (win_status.done)
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (div_status.done)
                begin
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mean_reg  <= div_mean;
            count_reg <= COUNT_W'(win_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mean_value      = mean_reg;
    assign samples_counted = count_reg;

endmodule

@@ tb/sv/moving_average_filter_checker.sv @@
module moving_average_filter_checker
    import mavf_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [MEAN_W-1:0]   mean_value,
    input  logic [COUNT_W-1:0]         samples_counted,
    output int                         errors,
    output int                         pending,
    output int                         means_seen
);

    typedef struct packed {
        logic [MEAN_W-1:0]  mean;
        logic [COUNT_W-1:0] count;
    } mean_beat_t;

    logic signed [SAMPLE_W-1:0] ring [WINDOW];
    int                         ring_pos;
    int                         ring_fill;
    longint                     ring_sum;
    mean_beat_t                 means_due [$];

    task automatic take_sample(input logic signed [SAMPLE_W-1:0] s);
        longint     avg;
        mean_beat_t beat;
        if (ring_fill < WINDOW)
        begin
            ring_fill++;
        end
        ring_sum = ring_sum + longint'(s) - longint'(ring[ring_pos]);
        ring[ring_pos] = s;
        ring_pos = (ring_pos + 1) % WINDOW;
        // signed division truncates toward zero
        avg = (ring_sum * 256) / longint'(ring_fill);
        beat.mean = avg[MEAN_W-1:0];
        beat.count = ring_fill[COUNT_W-1:0];
        means_due.push_back(beat);
    endtask

    task automatic check_mean();
        mean_beat_t want;
        means_seen++;
        if (means_due.size() == 0)
        begin
            $display("%0t unexpected beat: expected none, actual mean_value %0d samples_counted %0d",
                     $time, mean_value, samples_counted);
            errors++;
        end
        else
        begin
            want = means_due.pop_front();
            if (mean_value !== want.mean)
            begin
                $display("%0t mean_value: expected %0d, actual %0d",
                         $time, $signed(want.mean), mean_value);
                errors++;
            end
            if (samples_counted !== want.count)
            begin
                $display("%0t samples_counted: expected %0d, actual %0d",
                         $time, want.count, samples_counted);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring[i] = '0;
            end
            ring_pos = 0;
            ring_fill = 0;
            ring_sum = 0;
            means_due.delete();
            errors = 0;
            means_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_mean();
            end
            if (in_valid && !in_stall)
            begin
                take_sample(sample);
            end
            pending <= means_due.size();
        end
    end

endmodule

@@ tb/sv/moving_average_filter_core_tb.sv @@
module moving_average_filter_core_tb
    import mavf_pkg::*;
;

    localparam int WINDOW = 16;
    localparam int RANDOM_SAMPLES = 1000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [MEAN_W-1:0]   mean_value;
    logic [COUNT_W-1:0]         samples_counted;

    int errors;
    int pending;
    int means_seen;
    int samples_sent = 0;
    bit send_quiet = 1'b0;

    always #5 clk = ~clk;

    moving_average_filter_core #(
        .WINDOW(WINDOW)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mean_value(mean_value),
        .samples_counted(samples_counted)
    );

    moving_average_filter_checker #(
        .WINDOW(WINDOW)
    ) mean_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mean_value(mean_value),
        .samples_counted(samples_counted),
        .errors(errors),
        .pending(pending),
        .means_seen(means_seen)
    );

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        int gap;
        if (samples_sent % 64 == 0)
        begin
            send_quiet = ($urandom_range(0, 3) == 0);
        end
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            sample <= SAMPLE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= v;
        do @(posedge clk); while (in_stall !== 1'b0);
        samples_sent++;
    endtask

    // result side: stall a drawn number of cycles per beat
    initial
    begin : drain
        int  w;
        int  taken;
        bit  calm;
        taken = 0;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (taken % 48 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            w = calm ? 0 : $urandom_range(0, 17);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                do @(posedge clk); while (out_valid !== 1'b1);
                repeat (w - 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
            taken++;
        end
    end

    initial
    begin : stimulus
        int mode;
        int burst;
        logic signed [SAMPLE_W-1:0] v;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill from reset with the most negative value, then start pushing it out with edge values
        repeat (16) send_sample(-32768);
        repeat (4) send_sample(32767);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);

        while (samples_sent < RANDOM_SAMPLES + 25)
        begin
            mode = $urandom_range(0, 5);
            burst = (mode == 3 || mode == 4) ? $urandom_range(16, 24) : $urandom_range(4, 40);
            repeat (burst)
            begin
                case (mode)
                    2: v = SAMPLE_W'($urandom_range(0, 16) - 8);
                    3: v = 32767;
                    4: v = -32768;
                    5:
                    begin
                        case ($urandom_range(0, 4))
                            0: v = 32767;
                            1: v = -32768;
                            2: v = 0;
                            3: v = -1;
                            default: v = 1;
                        endcase
                    end
                    default: v = SAMPLE_W'($urandom);
                endcase
                send_sample(v);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d samples, checked %0d means", samples_sent, means_seen);
        $display("window fill from reset, saturation, wrap and extreme runs exercised");
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/mavf_pkg.sv
sv/mavf_window.sv
sv/mavf_divider.sv
sv/moving_average_filter_core.sv
tb/sv/moving_average_filter_checker.sv
tb/sv/moving_average_filter_core_tb.sv
